/* hw/rtl/odae_pkg.sv */
// Shared types, codes and helpers for the object dictionary access engine.
// Used by odae_table, odae_seq, the top level and the checker.
package odae_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
   localparam int KEY_W       = 24;
   localparam int ATTR_W      = 7;
   localparam int VALUE_W     = 32;
   localparam int CSR_COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_DEFINE   = 2'd0,
      OP_READ     = 2'd1,
      OP_WRITE    = 2'd2,
      OP_RESERVED = 2'd3
   } opcode_type;

   // Access classes
   localparam logic [2:0] ACC_RO_VAR = 3'd0;
   localparam logic [2:0] ACC_RW_VAR = 3'd1;
   localparam logic [2:0] ACC_RO_EVT = 3'd2;
   localparam logic [2:0] ACC_RW_EVT = 3'd3;
   localparam logic [2:0] ACC_CONST  = 3'd4;

   // Entry types and requested widths
   localparam logic [2:0] TYPE_U8  = 3'd0;
   localparam logic [2:0] TYPE_U16 = 3'd1;
   localparam logic [1:0] WK_U32   = 2'd2;

   // Access event codes
   localparam logic [1:0] AEV_NONE  = 2'd0;
   localparam logic [1:0] AEV_READ  = 2'd1;
   localparam logic [1:0] AEV_WRITE = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_ENTRY_COUNT  = 2'd0;
   localparam logic [1:0] CSR_ACCESS_EVENT = 2'd1;
   localparam logic [1:0] CSR_CHANGE_EVENT = 2'd2;

   typedef struct packed {
      logic [CSR_COUNT_W-1:0] entry_count;
      logic                   access_event_enable;
      logic                   change_event_enable;
   } cfg_type;

   typedef struct packed {
      opcode_type         opcode;
      logic               by_key;
      logic [SLOT_W-1:0]  slot_number;
      logic [15:0]        object_index;
      logic [7:0]         object_subindex;
      logic [1:0]         width_kind;
      logic [2:0]         entry_type;
      logic [2:0]         entry_access;
      logic               has_storage;
      logic [VALUE_W-1:0] data_word;
   } request_type;

   // Packed so that ok lands in bit 0 of the response word
   typedef struct packed {
      logic [3:0]         pad;
      logic [7:0]         event_subindex;
      logic [15:0]        event_index;
      logic [VALUE_W-1:0] old_value;
      logic               changed_event;
      logic [1:0]         access_event;
      logic [VALUE_W-1:0] read_value;
      logic               ok;
   } result_type;

   typedef struct packed {
      logic               key_en;
      logic               value_en;
      logic [SLOT_W-1:0]  addr;
      logic [KEY_W-1:0]   key;
      logic [ATTR_W-1:0]  attr;
      logic [VALUE_W-1:0] value;
   } wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } rd_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [ATTR_W-1:0]  attr;
      logic [VALUE_W-1:0] value;
   } slot_data_type;

   function automatic logic [VALUE_W-1:0] width_mask(input logic [2:0] kind);
      logic [VALUE_W-1:0] m;
      case (kind)
         TYPE_U8:  m = VALUE_W'(32'h0000_00FF);
         TYPE_U16: m = VALUE_W'(32'h0000_FFFF);
         default:  m = '1;
      endcase
      return m;
   endfunction

endpackage

/* hw/rtl/odae_table.sv */
// Entry storage: key, attribute and value memories, one write and one read port.
// Depends on odae_pkg.
module odae_table
   import odae_pkg::*;
(
   input  logic          clock,
   input  wr_type        wr,
   input  rd_type        rd,
   output slot_data_type rd_data
);

   logic [KEY_W-1:0]   key_ram_ff   [TABLE_SLOTS];
   logic [ATTR_W-1:0]  attr_ram_ff  [TABLE_SLOTS];
   logic [VALUE_W-1:0] value_ram_ff [TABLE_SLOTS];
   slot_data_type      rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_ram_ff[wr.addr]  <= wr.key;
         attr_ram_ff[wr.addr] <= wr.attr;
      end
      if (wr.key_en || wr.value_en) begin
         value_ram_ff[wr.addr] <= wr.value;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff.key   <= key_ram_ff[rd.addr];
         rd_data_ff.attr  <= attr_ram_ff[rd.addr];
         rd_data_ff.value <= value_ram_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/odae_seq.sv */
// Sequencer: walks the table through the shared key comparator, evaluates the access
// and holds the response register. Depends on odae_pkg.
module odae_seq
   import odae_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_valid,
   output logic          req_ready,
   input  request_type   req,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output result_type    rsp_data,
   output wr_type        wr,
   output rd_type        rd,
   input  slot_data_type rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEFINE,
      ST_SEARCH,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   request_type        req_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               pend_ff;
   result_type         result_ff;
   logic               rsp_valid_ff;
   result_type         rsp_data_ff;

   logic [COUNT_W-1:0] used;
   logic               key_hit;
   logic               match;
   logic               exhausted;
   logic               define_ok;
   logic [SLOT_W-1:0]  eval_slot;
   result_type         eval_res;
   logic               eval_store;
   logic [VALUE_W-1:0] eval_mask;
   logic [VALUE_W-1:0] new_value;
   logic [VALUE_W-1:0] prev_value;
   logic [2:0]         ent_type;
   logic [2:0]         ent_acc;
   logic               ent_sto;
   logic               kind_ok;

   assign used = (COUNT_W'(cfg.entry_count) > COUNT_W'(TABLE_SLOTS)) ?
                 COUNT_W'(TABLE_SLOTS) : COUNT_W'(cfg.entry_count);

   // Shared compare unit: one key per cycle
   assign key_hit   = (rd_data.key == {req_ff.object_index, req_ff.object_subindex});
   assign match     = pend_ff && (!req_ff.by_key || key_hit);
   assign exhausted = (cnt_ff >= used);
   assign eval_slot = SLOT_W'(cnt_ff - 1'b1);
   assign define_ok = (COUNT_W'(req_ff.slot_number) < COUNT_W'(TABLE_SLOTS));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ent_type   = rd_data.attr[2:0];
      ent_acc    = rd_data.attr[5:3];
      ent_sto    = rd_data.attr[6];
      eval_mask  = width_mask({1'b0, req_ff.width_kind});
      new_value  = req_ff.data_word & eval_mask;
      kind_ok    = (req_ff.width_kind <= WK_U32) && (ent_type == {1'b0, req_ff.width_kind});
      prev_value = '0;
      eval_store = 1'b0;
      eval_res   = '0;
      if (kind_ok) begin
         if (req_ff.opcode == OP_READ) begin
            if (ent_acc == ACC_CONST ||
                ((ent_acc == ACC_RO_VAR || ent_acc == ACC_RW_VAR) && ent_sto)) begin
               eval_res.read_value = rd_data.value & eval_mask;
               eval_res.ok         = 1'b1;
            end else if (ent_acc == ACC_RO_EVT || ent_acc == ACC_RW_EVT) begin
               eval_res.ok = 1'b1;
               if (cfg.access_event_enable) begin
                  eval_res.access_event = AEV_READ;
               end
            end
         end else begin
            if (ent_acc == ACC_RW_VAR && ent_sto) begin
               prev_value  = rd_data.value & eval_mask;
               eval_store  = 1'b1;
               eval_res.ok = 1'b1;
            end else if (ent_acc == ACC_RW_EVT) begin
               prev_value  = ~new_value & eval_mask;
               eval_res.ok = 1'b1;
               if (cfg.access_event_enable) begin
                  eval_res.access_event = AEV_WRITE;
               end
            end
            if (eval_res.ok && prev_value != new_value && cfg.change_event_enable) begin
               eval_res.changed_event = 1'b1;
               eval_res.old_value     = prev_value;
            end
         end
         if (eval_res.access_event != AEV_NONE || eval_res.changed_event) begin
            eval_res.event_index    = rd_data.key[KEY_W-1:8];
            eval_res.event_subindex = rd_data.key[7:0];
         end
      end
   end

   always_comb begin
      wr       = '0;
      rd       = '0;
      wr.key   = {req_ff.object_index, req_ff.object_subindex};
      wr.attr  = {req_ff.has_storage, req_ff.entry_access, req_ff.entry_type};
      if (state_ff == ST_DEFINE) begin
         wr.key_en = define_ok;
         wr.addr   = req_ff.slot_number;
         wr.value  = req_ff.data_word & width_mask(req_ff.entry_type);
      end else if (state_ff == ST_EVAL) begin
         wr.value_en = eval_store;
         wr.addr     = eval_slot;
         wr.value    = new_value;
      end
      if (state_ff == ST_SEARCH && !match && !exhausted) begin
         rd.en   = 1'b1;
         rd.addr = cnt_ff[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop valid after the transfer, unless the finish step reloads it
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req;
                  cnt_ff    <= req.by_key ? '0 : COUNT_W'(req.slot_number);
                  pend_ff   <= 1'b0;
                  result_ff <= '0;
                  if (req.opcode == OP_DEFINE) begin
                     state_ff <= ST_DEFINE;
                  end else if (req.opcode == OP_READ || req.opcode == OP_WRITE) begin
                     state_ff <= ST_SEARCH;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_DEFINE: begin
               result_ff.ok <= define_ok;
               state_ff     <= ST_FINISH;
            end
            ST_SEARCH: begin
               if (match) begin
                  state_ff <= ST_EVAL;
               end else if (exhausted) begin
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff  <= cnt_ff + 1'b1;
                  pend_ff <= 1'b1;
               end
            end
            ST_EVAL: begin
               result_ff <= eval_res;
               state_ff  <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/object_dictionary_access_engine.sv */
// From request transfer to response, an unused opcode goes straight to the finish step, a
// define writes its slot first, and an access reads k slots and then evaluates the entry if
// it finds one; k is the slots read, one key compare per cycle: 1 for a direct slot in use,
// 0 outside, up to entry_count (at most 64) for a key search. Throughput: one request at a
// time; req_tready rises as the response loads, so the next transfer can meet the response one.
// Sync active-high reset clears sequencer, response valid and CSRs; entry memories are not.
module object_dictionary_access_engine
   import odae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot_number[5:0], object_index[21:6], object_subindex[29:22], width_kind[31:30],
   // entry_type[34:32], entry_access[37:35], has_storage[38], data_word[70:39], zero[71]
   input  logic [71:0] req_tdata,
   // opcode[1:0], by_key[2]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ok[0], read_value[32:1], access_event[34:33], changed_event[35], old_value[67:36],
   // event_index[83:68], event_subindex[91:84], zero[95:92]
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   cfg_type       cfg_ff;
   request_type   req;
   result_type    rsp_data;
   wr_type        wr;
   rd_type        rd;
   slot_data_type rd_data;

   // Configuration registers: plain write, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:  cfg_ff.entry_count         <= csr_wdata;
            CSR_ACCESS_EVENT: cfg_ff.access_event_enable <= csr_wdata[0];
            CSR_CHANGE_EVENT: cfg_ff.change_event_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Unpack the request transfer
   always_comb begin
      req.opcode          = opcode_type'(req_tuser[1:0]);
      req.by_key          = req_tuser[2];
      req.slot_number     = req_tdata[5:0];
      req.object_index    = req_tdata[21:6];
      req.object_subindex = req_tdata[29:22];
      req.width_kind      = req_tdata[31:30];
      req.entry_type      = req_tdata[34:32];
      req.entry_access    = req_tdata[37:35];
      req.has_storage     = req_tdata[38];
      req.data_word       = req_tdata[70:39];
   end

   odae_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data),
      .wr        (wr),
      .rd        (rd),
      .rd_data   (rd_data)
   );

   odae_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign rsp_tdata = rsp_data;

endmodule

/* hw/rtl/odae_checker.sv */
// Port-level checks for the object dictionary access engine, bound to the top level.
// Depends on odae_pkg.
module odae_checker
   import odae_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        csr_we,
   input logic [1:0]  csr_index,
   input logic [6:0]  csr_wdata
);

   // A stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // Busy after each request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A failed operation reports nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata == '0)
      else $error("failed response carries data");

   // Events come only with success
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[34:33] != AEV_NONE || rsp_tdata[35]) |-> rsp_tdata[0])
      else $error("event without success");

   // No access event code beyond write notice
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:33] != 2'd3)
      else $error("bad access event code");

endmodule

bind object_dictionary_access_engine odae_checker u_checker (.*);

/* test/od_access_checker.sv */
`timescale 1ns / 100ps
// Response checker for the object dictionary access engine: tracks the dictionary table and
// the registers, predicts every response and compares it. Depends on odae_pkg.
module od_access_checker
   import odae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   output int          mismatches,
   output int          pending,
   output int          ok_total,
   output int          notice_total
);

   typedef struct {
      opcode_type  op;
      logic        by_key;
      logic [5:0]  slot;
      logic [15:0] idx;
      logic [7:0]  sub;
      logic [1:0]  wk;
      logic [2:0]  typ;
      logic [2:0]  acc;
      logic        sto;
      logic [31:0] data;
   } od_request_type;

   typedef struct {
      logic        ok;
      logic [31:0] rd;
      logic [1:0]  aev;
      logic        chg;
      logic [31:0] old;
      logic [15:0] eidx;
      logic [7:0]  esub;
   } od_response_type;

   od_response_type awaited[$];

   logic [23:0] key_mem   [TABLE_SLOTS];
   logic [2:0]  type_mem  [TABLE_SLOTS];
   logic [2:0]  acc_mem   [TABLE_SLOTS];
   logic        sto_mem   [TABLE_SLOTS];
   logic [31:0] value_mem [TABLE_SLOTS];

   logic [6:0] slots_cfg    = '0;
   logic       access_ev_on = 1'b0;
   logic       change_ev_on = 1'b0;

   od_request_type  req_now;
   od_response_type want;
   od_response_type got;
   int              rsp_seen = 0;

   function automatic logic [31:0] kind_mask(input logic [2:0] kind);
      case (kind)
         TYPE_U8:  return 32'h0000_00FF;
         TYPE_U16: return 32'h0000_FFFF;
         default:  return '1;
      endcase
   endfunction

   task automatic apply_request(input od_request_type q, output od_response_type e);
      int          used;
      int          hit;
      logic        found;
      logic [31:0] m;
      logic [31:0] nv;
      logic [31:0] prev;
      logic [2:0]  acc;
      logic        sto;
      e = '{default: '0};
      case (q.op) inside
         OP_DEFINE: begin
            key_mem[q.slot]   = {q.idx, q.sub};
            type_mem[q.slot]  = q.typ;
            acc_mem[q.slot]   = q.acc;
            sto_mem[q.slot]   = q.sto;
            value_mem[q.slot] = q.data & kind_mask(q.typ);
            e.ok = 1'b1;
         end
         OP_READ, OP_WRITE: begin
            used  = (slots_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(slots_cfg);
            found = 1'b0;
            hit   = 0;
            if (q.by_key) begin
               // first match wins
               for (int s = 0; s < used && !found; s++) begin
                  if (key_mem[s] == {q.idx, q.sub}) begin
                     found = 1'b1;
                     hit   = s;
                  end
               end
            end else begin
               hit   = q.slot;
               found = hit < used;
            end
            if (found && q.wk <= WK_U32 && type_mem[hit] == {1'b0, q.wk}) begin
               m   = kind_mask({1'b0, q.wk});
               acc = acc_mem[hit];
               sto = sto_mem[hit];
               if (q.op == OP_READ) begin
                  if (acc == ACC_CONST || ((acc == ACC_RO_VAR || acc == ACC_RW_VAR) && sto)) begin
                     e.rd = value_mem[hit] & m;
                     e.ok = 1'b1;
                  end else if (acc == ACC_RO_EVT || acc == ACC_RW_EVT) begin
                     e.ok = 1'b1;
                     if (access_ev_on) e.aev = AEV_READ;
                  end
               end else begin
                  nv   = q.data & m;
                  prev = '0;
                  if (acc == ACC_RW_VAR && sto) begin
                     prev = value_mem[hit] & m;
                     value_mem[hit] = nv;
                     e.ok = 1'b1;
                  end else if (acc == ACC_RW_EVT) begin
                     // event writes always look like a change
                     prev = ~nv & m;
                     e.ok = 1'b1;
                     if (access_ev_on) e.aev = AEV_WRITE;
                  end
                  if (e.ok && prev != nv && change_ev_on) begin
                     e.chg = 1'b1;
                     e.old = prev;
                  end
               end
               if (e.aev != AEV_NONE || e.chg) begin
                  e.eidx = key_mem[hit][23:8];
                  e.esub = key_mem[hit][7:0];
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d: %s expected %h, got %h", rsp_seen, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slots_cfg    = '0;
         access_ev_on = 1'b0;
         change_ev_on = 1'b0;
         awaited.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENTRY_COUNT:  slots_cfg    = csr_wdata;
               CSR_ACCESS_EVENT: access_ev_on = csr_wdata[0];
               CSR_CHANGE_EVENT: change_ev_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ok   = rsp_tdata[0];
            got.rd   = rsp_tdata[32:1];
            got.aev  = rsp_tdata[34:33];
            got.chg  = rsp_tdata[35];
            got.old  = rsp_tdata[67:36];
            got.eidx = rsp_tdata[83:68];
            got.esub = rsp_tdata[91:84];
            if (awaited.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with no request outstanding", rsp_seen);
            end else begin
               want = awaited.pop_front();
               note_field("ok", 32'(want.ok), 32'(got.ok));
               note_field("read_value", want.rd, got.rd);
               note_field("access_event", 32'(want.aev), 32'(got.aev));
               note_field("changed_event", 32'(want.chg), 32'(got.chg));
               note_field("old_value", want.old, got.old);
               note_field("event_index", 32'(want.eidx), 32'(got.eidx));
               note_field("event_subindex", 32'(want.esub), 32'(got.esub));
            end
            rsp_seen++;
         end
         if (req_tvalid && req_tready) begin
            req_now.op     = opcode_type'(req_tuser[1:0]);
            req_now.by_key = req_tuser[2];
            req_now.slot   = req_tdata[5:0];
            req_now.idx    = req_tdata[21:6];
            req_now.sub    = req_tdata[29:22];
            req_now.wk     = req_tdata[31:30];
            req_now.typ    = req_tdata[34:32];
            req_now.acc    = req_tdata[37:35];
            req_now.sto    = req_tdata[38];
            req_now.data   = req_tdata[70:39];
            apply_request(req_now, want);
            ok_total     += int'(want.ok);
            notice_total += (want.aev != AEV_NONE || want.chg) ? 1 : 0;
            awaited.push_back(want);
         end
      end
      pending = awaited.size();
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Top of the object dictionary access engine test: drives requests, register writes and
// response back-pressure, and reports the verdict. Depends on odae_pkg and od_access_checker.
module tb;
   import odae_pkg::*;

   // entry types, widths and an access class that the package does not name
   localparam logic [2:0] TYPE_U32     = 3'd2;
   localparam logic [2:0] TYPE_BOOL    = 3'd3;
   localparam logic [2:0] TYPE_UNKNOWN = 3'd4;
   localparam logic [2:0] ACC_BAD      = 3'd7;
   localparam logic [1:0] WK_U8        = 2'd0;
   localparam logic [1:0] WK_U16       = 2'd1;
   localparam logic [1:0] WK_NONE      = 2'd3;

   localparam int PHASES = 7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [6:0]  csr_wdata;

   int mismatch_total;
   int awaiting;
   int ok_total;
   int notice_total;

   // idle-free stretches on either side
   logic quiet_tx = 1'b0;
   logic quiet_rx = 1'b0;

   int sent_count     = 0;
   int settings_count = 0;

   // rough view of the table, used only to aim the stimulus at live entries
   logic [23:0] shadow_key   [TABLE_SLOTS];
   logic [2:0]  shadow_type  [TABLE_SLOTS];
   logic [31:0] shadow_value [TABLE_SLOTS];

   always #5 clock = ~clock;

   object_dictionary_access_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   od_access_checker access_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatch_total),
      .pending      (awaiting),
      .ok_total     (ok_total),
      .notice_total (notice_total)
   );

   // One request transfer. Enter and leave on a falling edge; a zero gap keeps tvalid high
   // so back-to-back transfers get through.
   task automatic send_request(input opcode_type op, input logic by_key, input logic [5:0] slot,
                               input logic [15:0] idx, input logic [7:0] sub,
                               input logic [1:0] wk, input logic [2:0] typ,
                               input logic [2:0] acc, input logic sto,
                               input logic [31:0] data);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= {by_key, op};
      req_tdata  <= {1'b0, data, sto, acc, typ, wk, sub, idx, slot};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (op == OP_DEFINE) begin
         shadow_key[slot]   = {idx, sub};
         shadow_type[slot]  = typ;
         shadow_value[slot] = data;
      end else if (op == OP_WRITE && !by_key) begin
         shadow_value[slot] = data;
      end
      sent_count++;
   endtask

   // Define a slot; the fields a define ignores carry noise.
   task automatic define_slot(input logic [5:0] slot, input logic [15:0] idx,
                              input logic [7:0] sub, input logic [2:0] typ,
                              input logic [2:0] acc, input logic sto, input logic [31:0] data);
      send_request(OP_DEFINE, 1'($urandom), slot, idx, sub, 2'($urandom), typ, acc, sto, data);
   endtask

   // Read, write or reserved opcode; the define-only fields carry noise.
   task automatic access_entry(input opcode_type op, input logic by_key, input logic [5:0] slot,
                               input logic [15:0] idx, input logic [7:0] sub,
                               input logic [1:0] wk, input logic [31:0] data);
      send_request(op, by_key, slot, idx, sub, wk, 3'($urandom), 3'($urandom), 1'($urandom),
                   data);
   endtask

   // Mostly well-formed entries; keys often drawn from a small pool so duplicates appear.
   task automatic define_random(input logic [5:0] slot);
      logic [15:0] idx;
      logic [7:0]  sub;
      logic [2:0]  typ;
      logic [2:0]  acc;
      if ($urandom_range(0, 1) != 0) begin
         idx = 16'h2000 | 16'($urandom_range(0, 7));
         sub = 8'($urandom_range(0, 3));
      end else begin
         idx = 16'($urandom);
         sub = 8'($urandom);
      end
      typ = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(3, 7));
      acc = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      define_slot(slot, idx, sub, typ, acc, $urandom_range(0, 99) < 85, $urandom);
   endtask

   task automatic random_request();
      int          roll;
      int          s;
      logic [15:0] idx;
      logic [7:0]  sub;
      logic [1:0]  wk;
      logic [31:0] data;
      roll = $urandom_range(0, 99);
      s    = $urandom_range(0, TABLE_SLOTS - 1);
      if (roll < 15) begin
         define_random(6'(s));
      end else if (roll < 95) begin
         // aim at a live key and the entry's own width most of the time
         if ($urandom_range(0, 3) != 0) {idx, sub} = shadow_key[s];
         else {idx, sub} = 24'($urandom);
         if (shadow_type[s] <= TYPE_U32 && $urandom_range(0, 4) != 0) wk = shadow_type[s][1:0];
         else wk = 2'($urandom_range(0, 3));
         // repeat the last value now and then so unchanged writes show up
         data = ($urandom_range(0, 6) == 0) ? shadow_value[s] : $urandom;
         access_entry((roll < 55) ? OP_READ : OP_WRITE, 1'($urandom), 6'(s), idx, sub, wk, data);
      end else begin
         access_entry(OP_RESERVED, 1'($urandom), 6'($urandom), 16'($urandom), 8'($urandom),
                      2'($urandom), $urandom);
      end
   endtask

   // Hold off the sender until every response is back, then let the engine settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   // Write all three registers on consecutive edges; enable writes carry junk upper bits.
   task automatic set_config(input logic [6:0] count, input logic aev_on, input logic chg_on);
      csr_we    <= 1'b1;
      csr_index <= CSR_ENTRY_COUNT;
      csr_wdata <= count;
      @(negedge clock);
      csr_index <= CSR_ACCESS_EVENT;
      csr_wdata <= {6'($urandom), aev_on};
      @(negedge clock);
      csr_index <= CSR_CHANGE_EVENT;
      csr_wdata <= {6'($urandom), chg_on};
      @(negedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // Response back-pressure: draw a stall per transfer, zero during quiet stretches.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = quiet_rx ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      logic [6:0] phase_count [PHASES] = '{7'd64, 7'd127, 7'd9, 7'd65, 7'd0, 7'd40, 7'd64};
      logic       phase_aev   [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      logic       phase_chg   [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
      logic       phase_qtx   [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      logic       phase_qrx   [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      int         phase_items [PHASES] = '{280, 280, 240, 240, 60, 260, 280};

      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_ENTRY_COUNT;
      csr_wdata  = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table: defines work while no slot is in use. Slots 2 and 4 share a key
      // so a search must stop at slot 2; slot 63 stays outside the slots in use.
      define_slot(0, 16'h0000, 8'h00, TYPE_U8, ACC_RW_VAR, 1'b1, 32'hFFFF_FFFF);
      define_slot(1, 16'hFFFF, 8'hFF, TYPE_U16, ACC_RO_VAR, 1'b1, 32'h1234_5678);
      define_slot(2, 16'h1234, 8'h01, TYPE_U32, ACC_RW_EVT, 1'b0, 32'h0000_0000);
      define_slot(3, 16'h2000, 8'h02, TYPE_U32, ACC_CONST, 1'b0, 32'hDEAD_BEEF);
      define_slot(4, 16'h1234, 8'h01, TYPE_U8, ACC_RW_VAR, 1'b1, 32'h0000_005A);
      define_slot(5, 16'h3000, 8'h00, TYPE_BOOL, ACC_RW_VAR, 1'b1, 32'h0000_0001);
      define_slot(6, 16'h3001, 8'h00, TYPE_U8, ACC_RW_VAR, 1'b0, 32'h0000_0077);
      define_slot(7, 16'h3002, 8'h00, TYPE_U16, ACC_RO_EVT, 1'b1, 32'h0000_ABCD);
      define_slot(8, 16'h3003, 8'h00, TYPE_U16, ACC_BAD, 1'b1, 32'h0000_1111);
      define_slot(63, 16'h7777, 8'h77, TYPE_UNKNOWN, ACC_RW_VAR, 1'b1, 32'hCAFE_F00D);
      drain();
      set_config(7'd9, 1'b1, 1'b1);

      // variable read, changing write, unchanged write
      access_entry(OP_READ, 1'b0, 0, 16'h0, 8'h0, WK_U8, 32'h0);
      access_entry(OP_WRITE, 1'b0, 0, 16'h0, 8'h0, WK_U8, 32'hFFFF_FF00);
      access_entry(OP_WRITE, 1'b0, 0, 16'h0, 8'h0, WK_U8, 32'h0000_0000);
      // key search at the top key; write to read-only fails
      access_entry(OP_READ, 1'b1, 0, 16'hFFFF, 8'hFF, WK_U16, 32'h0);
      access_entry(OP_WRITE, 1'b0, 1, 16'h0, 8'h0, WK_U16, 32'h0000_0001);
      // event read and write through the duplicated key
      access_entry(OP_READ, 1'b1, 0, 16'h1234, 8'h01, WK_U32, 32'h0);
      access_entry(OP_WRITE, 1'b1, 0, 16'h1234, 8'h01, WK_U32, 32'hFFFF_FFFF);
      // constant read, constant write
      access_entry(OP_READ, 1'b0, 3, 16'h0, 8'h0, WK_U32, 32'h0);
      access_entry(OP_WRITE, 1'b0, 3, 16'h0, 8'h0, WK_U32, 32'h0000_0001);
      // width mismatch, boolean entry, no storage, read-only event, bad access class
      access_entry(OP_READ, 1'b0, 4, 16'h0, 8'h0, WK_U16, 32'h0);
      access_entry(OP_READ, 1'b0, 5, 16'h0, 8'h0, WK_U8, 32'h0);
      access_entry(OP_READ, 1'b0, 6, 16'h0, 8'h0, WK_U8, 32'h0);
      access_entry(OP_READ, 1'b0, 7, 16'h0, 8'h0, WK_U16, 32'h0);
      access_entry(OP_READ, 1'b0, 8, 16'h0, 8'h0, WK_U16, 32'h0);
      // slot and key outside the slots in use, meaningless width, reserved opcode
      access_entry(OP_READ, 1'b0, 63, 16'h0, 8'h0, WK_U32, 32'h0);
      access_entry(OP_READ, 1'b1, 0, 16'h7777, 8'h77, WK_U32, 32'h0);
      access_entry(OP_READ, 1'b0, 0, 16'h0, 8'h0, WK_NONE, 32'h0);
      access_entry(OP_RESERVED, 1'b1, 6'h3F, 16'hFFFF, 8'hFF, WK_NONE, 32'hFFFF_FFFF);

      // Fill every slot so any slot count and any key search stays on defined entries.
      for (int s = 0; s < TABLE_SLOTS; s++) define_random(6'(s));

      // Random phases, each behind a full drain and a new register setting.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         set_config(phase_count[p], phase_aev[p], phase_chg[p]);
         quiet_tx = phase_qtx[p];
         quiet_rx = phase_qrx[p];
         repeat (phase_items[p]) random_request();
      end

      req_tvalid <= 1'b0;
      quiet_rx = 1'b0;
      for (int w = 0; w < 5000 && awaiting != 0; w++) @(negedge clock);
      repeat (80) @(negedge clock);

      $display("covered %0d requests under %0d register settings", sent_count, settings_count);
      $display("%0d requests succeeded, %0d raised an access or change notice",
               ok_total, notice_total);
      if (mismatch_total == 0 && awaiting == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
